### rtl/core/stp_pkg.sv
// ----------------------------------------------------------------------------
// Sine tone PCM generator package
// Shared constants, configuration and stage types, and the quarter-wave sine
// table builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stp_pkg;

   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int DECAY_WINDOW     = 16;
   localparam int PHASE_BITS       = 32;

   localparam int INDEX_BITS  = 32;
   localparam int STEP_BITS   = 32;
   localparam int GAIN_BITS   = 16;
   localparam int PCM_BITS    = 16;
   localparam int SINE_BITS   = 16;
   localparam int VALUE_BITS  = 29;
   localparam int TABLE_BITS  = $clog2(SINE_TABLE_DEPTH);
   localparam int ADDR_BITS   = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int DECAY_BITS  = $clog2(DECAY_WINDOW + 1);
   localparam int DECAY_SHIFT = $clog2(DECAY_WINDOW);

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam int          ONE_Q27     = 134217728;
   localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

   localparam int FMT_WIDE_BIT   = 0;
   localparam int FMT_STEREO_BIT = 1;

   typedef enum logic [1:0] {
      REG_SAMPLE_FORMAT  = 2'd0,
      REG_PHASE_STEP     = 2'd1,
      REG_AMPLITUDE_GAIN = 2'd2,
      REG_SOUND_LENGTH   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                  sample_format;
      logic [STEP_BITS-1:0]        phase_step;
      logic signed [GAIN_BITS-1:0] amplitude_gain;
      logic [INDEX_BITS-1:0]       sound_length;
   } cfg_type;

   typedef struct packed {
      logic                  in_range;
      logic                  final_sample;
      logic [DECAY_BITS-1:0] decay_gain;
   } meta_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      meta_type              meta;
   } phase_stage_type;

   typedef struct packed {
      logic [SINE_BITS-1:0] sine_mag;
      logic                 negate;
      meta_type             meta;
   } sine_stage_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      meta_type                     meta;
   } gain_stage_type;

   typedef struct packed {
      logic signed [PCM_BITS-1:0] pcm;
      meta_type                   meta;
   } pcm_stage_type;

   typedef struct packed {
      logic signed [PCM_BITS-1:0] left_sample;
      logic signed [PCM_BITS-1:0] right_sample;
      logic                       in_range;
      logic                       final_sample;
   } rsp_type;

   typedef logic [SINE_BITS-1:0] sine_rom_type [SINE_TABLE_DEPTH + 1];

   // Sine of a quarter-turn fraction in Q15, from an eight-term series in Q30.
   function automatic logic [SINE_BITS-1:0] sine_entry(input logic [63:0] k);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        t;
      logic signed [63:0] s;
      logic [63:0]        r;
      x  = (HALF_PI_Q30 * k + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x) >> 30;
      t  = x;
      s  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
         t = ((t * x2) >> 30) / TAYLOR_DIV[n-1];
         if (n[0]) begin
            s = s - $signed(t);
         end else begin
            s = s + $signed(t);
         end
      end
      if (s < 0) begin
         s = 64'sd0;
      end
      if (s > $signed(ONE_Q30)) begin
         s = $signed(ONE_Q30);
      end
      r = ($unsigned(s) + 64'd16384) >> 15;
      return r[SINE_BITS-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         rom[k] = sine_entry(64'(k));
      end
      return rom;
   endfunction

endpackage

### rtl/core/stp_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries the sample index of each requested sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stp_req_if
   import stp_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] sample_index;

   modport source (output valid, output sample_index, input ready);
   modport sink (input valid, input sample_index, output ready);
endinterface

### rtl/core/stp_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one PCM sample pair with its range flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stp_rsp_if
   import stp_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic signed [PCM_BITS-1:0] left_sample;
   logic signed [PCM_BITS-1:0] right_sample;
   logic                       in_range;
   logic                       final_sample;

   modport source (output valid, output left_sample, output right_sample,
                   output in_range, output final_sample, input ready);
   modport sink (input valid, input left_sample, input right_sample,
                 input in_range, input final_sample, output ready);
endinterface

### rtl/core/stp_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data written to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stp_csr_if
   import stp_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [1:0]            reg_index;
   logic [STEP_BITS-1:0]  write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

### rtl/core/stp_csr.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds sample format, phase step, amplitude gain and sound length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_csr
   import stp_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   stp_csr_if.sink csr_chan,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.reg_index))
            REG_SAMPLE_FORMAT: begin
               cfg_in.sample_format = csr_chan.write_data[1:0];
            end
            REG_PHASE_STEP: begin
               cfg_in.phase_step = csr_chan.write_data;
            end
            REG_AMPLITUDE_GAIN: begin
               cfg_in.amplitude_gain = $signed(csr_chan.write_data[GAIN_BITS-1:0]);
            end
            REG_SOUND_LENGTH: begin
               cfg_in.sound_length = csr_chan.write_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_format  <= 2'd1;
         cfg_ff.phase_step     <= '0;
         cfg_ff.amplitude_gain <= GAIN_BITS'(4096);
         cfg_ff.sound_length   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/stp_phase.sv
// ----------------------------------------------------------------------------
// Phase stage
// Multiplies the sample index by the phase step and works out the range,
// last-sample and fade-out factor of the index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_phase
   import stp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  logic [INDEX_BITS-1:0] up_index,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output phase_stage_type       dn_data
);

   logic                  valid_ff;
   logic                  valid_in;
   phase_stage_type       data_ff;
   phase_stage_type       data_in;
   logic [63:0]           product;
   logic [INDEX_BITS:0]   decay_diff;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      product    = 64'(up_index) * 64'(cfg.phase_step);
      decay_diff = {1'b0, up_index} + (INDEX_BITS + 1)'(DECAY_WINDOW)
                   - {1'b0, cfg.sound_length};
      data_in.phase              = product[PHASE_BITS-1:0];
      data_in.meta.in_range      = up_index < cfg.sound_length;
      data_in.meta.final_sample  = ({1'b0, up_index} + (INDEX_BITS + 1)'(1))
                                   == {1'b0, cfg.sound_length};
      if (decay_diff[INDEX_BITS]) begin
         data_in.meta.decay_gain = DECAY_BITS'(DECAY_WINDOW);
      end else begin
         data_in.meta.decay_gain = DECAY_BITS'(DECAY_WINDOW)
                                   - decay_diff[DECAY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/core/stp_sine_lookup.sv
// ----------------------------------------------------------------------------
// Sine lookup stage
// Folds the phase into one quadrant and reads the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_sine_lookup
   import stp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            up_valid,
   output logic            up_ready,
   input  phase_stage_type up_data,
   output logic            dn_valid,
   input  logic            dn_ready,
   output sine_stage_type  dn_data
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic                  valid_ff;
   logic                  valid_in;
   logic [SINE_BITS-1:0]  sine_ff;
   logic                  negate_ff;
   meta_type              meta_ff;
   logic [1:0]            quadrant;
   logic [ADDR_BITS-1:0]  fraction;
   logic [ADDR_BITS-1:0]  rom_addr;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign dn_valid = valid_ff;

   assign quadrant = up_data.phase[PHASE_BITS-1 -: 2];
   assign fraction = ADDR_BITS'(up_data.phase[PHASE_BITS-3 -: TABLE_BITS]);
   assign rom_addr = quadrant[0] ? ADDR_BITS'(SINE_TABLE_DEPTH) - fraction : fraction;

   always_comb begin
      dn_data.sine_mag = sine_ff;
      dn_data.negate   = negate_ff;
      dn_data.meta     = meta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         sine_ff   <= SINE_ROM[rom_addr];
         negate_ff <= quadrant[1];
         meta_ff   <= up_data.meta;
      end
   end

endmodule

### rtl/core/stp_gain.sv
// ----------------------------------------------------------------------------
// Gain stage
// Applies the signed sine, scales it by the amplitude gain and clamps the
// product to plus or minus one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_gain
   import stp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           up_valid,
   output logic           up_ready,
   input  sine_stage_type up_data,
   output logic           dn_valid,
   input  logic           dn_ready,
   output gain_stage_type dn_data
);

   localparam int PROD_BITS = SINE_BITS + 1 + GAIN_BITS;
   localparam logic signed [PROD_BITS-1:0] LIMIT_POS = PROD_BITS'(ONE_Q27);
   localparam logic signed [PROD_BITS-1:0] LIMIT_NEG = -PROD_BITS'(ONE_Q27);

   logic                          valid_ff;
   logic                          valid_in;
   gain_stage_type                data_ff;
   gain_stage_type                data_in;
   logic signed [SINE_BITS:0]     sine_signed;
   logic signed [PROD_BITS-1:0]   product;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      sine_signed = up_data.negate ? -$signed({1'b0, up_data.sine_mag})
                                   : $signed({1'b0, up_data.sine_mag});
      product     = PROD_BITS'(sine_signed) * PROD_BITS'(cfg.amplitude_gain);
      if (product > LIMIT_POS) begin
         data_in.value = VALUE_BITS'(LIMIT_POS);
      end else if (product < LIMIT_NEG) begin
         data_in.value = VALUE_BITS'(LIMIT_NEG);
      end else begin
         data_in.value = VALUE_BITS'(product);
      end
      data_in.meta = up_data.meta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/core/stp_pcm.sv
// ----------------------------------------------------------------------------
// PCM conversion stage
// Converts the clamped value to 16-bit signed or 8-bit unsigned PCM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_pcm
   import stp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           up_valid,
   output logic           up_ready,
   input  gain_stage_type up_data,
   output logic           dn_valid,
   input  logic           dn_ready,
   output pcm_stage_type  dn_data
);

   localparam int MAG_BITS  = VALUE_BITS - 1;
   localparam int WIDE_BITS = MAG_BITS + 15;
   localparam int BYTE_BITS = VALUE_BITS + 8;
   localparam logic signed [BYTE_BITS-1:0] BYTE_BIAS = BYTE_BITS'(128) <<< 27;

   logic                          valid_ff;
   logic                          valid_in;
   pcm_stage_type                 data_ff;
   pcm_stage_type                 data_in;
   logic [MAG_BITS-1:0]           magnitude;
   logic [WIDE_BITS-1:0]          wide_product;
   logic [PCM_BITS-1:0]           wide_scaled;
   logic signed [BYTE_BITS-1:0]   byte_sum;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      magnitude    = up_data.value[VALUE_BITS-1] ? MAG_BITS'(-up_data.value)
                                                 : MAG_BITS'(up_data.value);
      wide_product = WIDE_BITS'(magnitude) * WIDE_BITS'(32767);
      wide_scaled  = wide_product[27 +: PCM_BITS];
      byte_sum     = BYTE_BITS'(up_data.value) * BYTE_BITS'(127) + BYTE_BIAS;
      if (cfg.sample_format[FMT_WIDE_BIT]) begin
         data_in.pcm = up_data.value[VALUE_BITS-1] ? -$signed(wide_scaled)
                                                   : $signed(wide_scaled);
      end else begin
         data_in.pcm = $signed({8'd0, byte_sum[27 +: 8]});
      end
      data_in.meta = up_data.meta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/core/stp_fade.sv
// ----------------------------------------------------------------------------
// Fade-out and output stage
// Scales the final samples of the sound toward zero, masks out-of-range
// indexes and holds the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_fade
   import stp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          up_valid,
   output logic          up_ready,
   input  pcm_stage_type up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output rsp_type       dn_data
);

   localparam int FADE_BITS = PCM_BITS + DECAY_BITS;

   logic                        valid_ff;
   logic                        valid_in;
   rsp_type                     data_ff;
   rsp_type                     data_in;
   logic [PCM_BITS-1:0]         magnitude;
   logic [FADE_BITS-1:0]        fade_product;
   logic [PCM_BITS-1:0]         faded;
   logic signed [PCM_BITS-1:0]  sample;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      magnitude    = up_data.pcm[PCM_BITS-1] ? PCM_BITS'(-up_data.pcm)
                                             : PCM_BITS'(up_data.pcm);
      fade_product = FADE_BITS'(magnitude) * FADE_BITS'(up_data.meta.decay_gain);
      faded        = fade_product[DECAY_SHIFT +: PCM_BITS];
      if (!up_data.meta.in_range) begin
         sample = '0;
      end else if (up_data.pcm[PCM_BITS-1]) begin
         sample = -$signed(faded);
      end else begin
         sample = $signed(faded);
      end
      data_in.left_sample  = sample;
      data_in.right_sample = cfg.sample_format[FMT_STEREO_BIT] ? sample : '0;
      data_in.in_range     = up_data.meta.in_range;
      data_in.final_sample = up_data.meta.in_range && up_data.meta.final_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/core/sine_tone_pcm_generator.sv
// ----------------------------------------------------------------------------
// Sine tone PCM generator
// Each request transaction carries a sample index and yields exactly one
// response transaction with the PCM sample of a sine tone at that index.
// The block is a five-stage pipeline (phase multiply, quarter-wave ROM
// read, gain and clamp, PCM conversion, fade-out and output register) that
// takes one request per clock while the response is not stalled; a stalled
// response holds the pipeline in place stage by stage, and empty stages keep
// accepting. The sine ROM is a constant table and needs no fill after reset.
// Configuration is written through the csr channel, which is always ready;
// the user must write it only while no transaction is in flight, which the
// block does not enforce. The fade-out window assumes a power-of-two length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_tone_pcm_generator
   import stp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   stp_req_if.sink   req_chan,
   stp_rsp_if.source rsp_chan,
   stp_csr_if.sink   csr_chan
);

   cfg_type         cfg;
   logic            phase_valid;
   logic            phase_ready;
   phase_stage_type phase_data;
   logic            sine_valid;
   logic            sine_ready;
   sine_stage_type  sine_data;
   logic            gain_valid;
   logic            gain_ready;
   gain_stage_type  gain_data;
   logic            pcm_valid;
   logic            pcm_ready;
   pcm_stage_type   pcm_data;
   rsp_type         rsp_data;

   stp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   stp_phase u_phase (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (req_chan.valid),
      .up_ready (req_chan.ready),
      .up_index (req_chan.sample_index),
      .dn_valid (phase_valid),
      .dn_ready (phase_ready),
      .dn_data  (phase_data)
   );

   stp_sine_lookup u_sine_lookup (
      .clock    (clock),
      .reset    (reset),
      .up_valid (phase_valid),
      .up_ready (phase_ready),
      .up_data  (phase_data),
      .dn_valid (sine_valid),
      .dn_ready (sine_ready),
      .dn_data  (sine_data)
   );

   stp_gain u_gain (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (sine_valid),
      .up_ready (sine_ready),
      .up_data  (sine_data),
      .dn_valid (gain_valid),
      .dn_ready (gain_ready),
      .dn_data  (gain_data)
   );

   stp_pcm u_pcm (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (gain_valid),
      .up_ready (gain_ready),
      .up_data  (gain_data),
      .dn_valid (pcm_valid),
      .dn_ready (pcm_ready),
      .dn_data  (pcm_data)
   );

   stp_fade u_fade (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (pcm_valid),
      .up_ready (pcm_ready),
      .up_data  (pcm_data),
      .dn_valid (rsp_chan.valid),
      .dn_ready (rsp_chan.ready),
      .dn_data  (rsp_data)
   );

   assign rsp_chan.left_sample  = rsp_data.left_sample;
   assign rsp_chan.right_sample = rsp_data.right_sample;
   assign rsp_chan.in_range     = rsp_data.in_range;
   assign rsp_chan.final_sample = rsp_data.final_sample;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Sine tone PCM generator testbench
// Drives sample indices into the generator under several register settings
// and idle patterns. A predictor built into the bench computes each PCM
// sample pair with its range flags, and every response transaction is
// compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
   import stp_pkg::*;
   ;

   localparam int     LUT_DEPTH      = 1024;
   localparam longint FADE_LEN       = 64'sd16;
   localparam longint FULL_SCALE_Q27 = 64'sd134217728;
   localparam longint HALF_PI_Q30    = 64'sd1686629713;
   localparam longint UNITY_Q30      = 64'sd1073741824;
   localparam int     PHASE_COUNT    = 8;
   localparam int     PHASE_ITEMS    = 230;

   typedef struct {
      logic [31:0] index;
      rsp_type     pcm;
   } pcm_expect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stp_req_if req_bus ();
   stp_rsp_if rsp_bus ();
   stp_csr_if csr_bus ();

   sine_tone_pcm_generator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   int                sine_q15_lut [0:LUT_DEPTH];
   logic [1:0]        cfg_format = 2'd1;
   logic [31:0]       cfg_step   = 32'd0;
   logic signed [15:0] cfg_gain  = 16'sd4096;
   logic [31:0]       cfg_length = 32'd0;

   logic [31:0]       pending_index [$];
   pcm_expect_type    expected_pcm [$];
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                error_count    = 0;

   always #1 clock = ~clock;

   function automatic int quarter_sine_q15(input int k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x    = (longint'(HALF_PI_Q30) * longint'(k) + LUT_DEPTH / 2) / LUT_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > UNITY_Q30) begin
         acc = UNITY_Q30;
      end
      return int'((acc + 16384) >>> 15);
   endfunction

   function automatic rsp_type predict_pcm(input logic [31:0] index);
      rsp_type     pcm_out;
      logic [31:0] phase;
      int          addr;
      longint      position;
      longint      length;
      longint      level;
      longint      pcm;
      pcm_out  = '0;
      position = longint'(index);
      length   = longint'(cfg_length);
      if (position < length) begin
         phase = index * cfg_step;
         addr  = int'(phase[29:20]);
         if (phase[30]) begin
            addr = LUT_DEPTH - addr;
         end
         level = longint'(sine_q15_lut[addr]) * longint'(cfg_gain);
         if (phase[31]) begin
            level = -level;
         end
         if (level > FULL_SCALE_Q27) begin
            level = FULL_SCALE_Q27;
         end
         if (level < -FULL_SCALE_Q27) begin
            level = -FULL_SCALE_Q27;
         end
         if (cfg_format[FMT_WIDE_BIT]) begin
            pcm = (level * 32767) / FULL_SCALE_Q27;
         end else begin
            pcm = (level * 127 + 128 * FULL_SCALE_Q27) / FULL_SCALE_Q27;
         end
         // Inside the fade-out window the gain is (length - position) / window.
         if (position + FADE_LEN >= length) begin
            pcm = (pcm * (length - position)) / FADE_LEN;
         end
         pcm_out.left_sample  = 16'(pcm);
         pcm_out.right_sample = cfg_format[FMT_STEREO_BIT] ? 16'(pcm) : 16'sd0;
         pcm_out.in_range     = 1'b1;
         pcm_out.final_sample = (position + 1 == length);
      end
      return pcm_out;
   endfunction

   function automatic logic [31:0] pick_index();
      int          sel;
      logic [31:0] tail;
      sel = $urandom_range(99);
      if (sel < 15 || cfg_length == 0) begin
         return $urandom;
      end
      tail = (cfg_length < 24) ? cfg_length : 32'd24;
      if (sel < 55) begin
         return cfg_length - $urandom_range(tail, 1);
      end else if (sel < 85) begin
         return $urandom_range(cfg_length - 1, 0);
      end else if (sel < 95) begin
         return cfg_length + $urandom_range(3, 0);
      end
      return 32'hFFFF_FFFF;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_sample(input rsp_type got);
      pcm_expect_type want;
      if (expected_pcm.size() == 0) begin
         report_error($sformatf("response with no request pending: %h", got));
         return;
      end
      want = expected_pcm.pop_front();
      if (got.left_sample !== want.pcm.left_sample) begin
         report_error($sformatf("index %0d left_sample got %0d want %0d",
                                want.index, got.left_sample, want.pcm.left_sample));
      end
      if (got.right_sample !== want.pcm.right_sample) begin
         report_error($sformatf("index %0d right_sample got %0d want %0d",
                                want.index, got.right_sample, want.pcm.right_sample));
      end
      if (got.in_range !== want.pcm.in_range) begin
         report_error($sformatf("index %0d in_range got %b want %b",
                                want.index, got.in_range, want.pcm.in_range));
      end
      if (got.final_sample !== want.pcm.final_sample) begin
         report_error($sformatf("index %0d final_sample got %b want %b",
                                want.index, got.final_sample, want.pcm.final_sample));
      end
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_index.size() != 0 || req_bus.valid || expected_pcm.size() != 0);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [31:0] data);
      @(posedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= which;
      csr_bus.write_data <= data;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (which)
         REG_SAMPLE_FORMAT:  cfg_format = data[1:0];
         REG_PHASE_STEP:     cfg_step   = data;
         REG_AMPLITUDE_GAIN: cfg_gain   = data[15:0];
         REG_SOUND_LENGTH:   cfg_length = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [1:0] format, input logic [31:0] step,
                             input logic [31:0] gain_word, input logic [31:0] length);
      wait_idle();
      write_reg(REG_SAMPLE_FORMAT, {30'($urandom), format});
      write_reg(REG_PHASE_STEP, step);
      write_reg(REG_AMPLITUDE_GAIN, gain_word);
      write_reg(REG_SOUND_LENGTH, length);
      @(negedge clock);
   endtask

   // Request driver: presents queued indices and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_pcm.push_back('{req_bus.sample_index, predict_pcm(req_bus.sample_index)});
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_index.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid        <= 1'b1;
               req_bus.sample_index <= pending_index.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each response transaction and drives backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_sample(rsp_type'{rsp_bus.left_sample, rsp_bus.right_sample,
                                   rsp_bus.in_range, rsp_bus.final_sample});
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #2_000_000;
      $display("sine_tone_pcm_generator: mismatch");
      $finish;
   end

   initial begin
      logic [1:0]  format;
      logic [31:0] step;
      logic [31:0] gain_word;
      logic [31:0] length;
      for (int k = 0; k <= LUT_DEPTH; k++) begin
         sine_q15_lut[k] = quarter_sine_q15(k);
      end
      req_bus.valid        = 1'b0;
      req_bus.sample_index = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.reg_index    = REG_SAMPLE_FORMAT;
      csr_bus.write_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings give a zero-length sound, so every index is out of range.
      pending_index = {32'd0, 32'd1, 32'hFFFF_FFFF};

      // A sixteenth of a turn per sample walks through all four quadrants.
      set_config(2'd3, 32'h1000_0000, 32'd4096, 32'd40);
      pending_index = {32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd12,
                       32'd23, 32'd24, 32'd30, 32'd39, 32'd40, 32'hFFFF_FFFF};

      // Most negative gain on a sound shorter than the fade-out window.
      set_config(2'd0, 32'h1000_0000, 32'h0000_8000, 32'd5);
      pending_index = {32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5};

      set_config(2'd2, 32'h1000_0000, 32'h0000_7FFF, 32'd40);
      pending_index = {32'd2, 32'd6};

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         format    = 2'(ph);
         step      = $urandom;
         gain_word = $urandom;
         length    = $urandom_range(2000, 17);
         case (ph)
            0: begin
               step      = 32'hFFFF_FFFF;
               gain_word = 32'h0000_8000;
               length    = 32'd16;
            end
            1: begin
               step      = 32'd0;
               gain_word = 32'h0000_7FFF;
            end
            2: begin
               gain_word = 32'd0;
               length    = 32'hFFFF_FFFF;
            end
            3: begin
               step      = 32'h4000_0000;
               gain_word = 32'h0000_FFFF;
               length    = 32'd7;
            end
            5: length = 32'd1;
            6: length = $urandom;
            default: ;
         endcase
         set_config(format, step, gain_word, length);
         send_idle_pct  = (ph % 4 == 1) ? 54 : (ph % 4 == 3) ? 30 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 30 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == PHASE_ITEMS / 2) begin
               wait_idle();
            end
            pending_index.push_back(pick_index());
         end
      end

      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (expected_pcm.size() != 0) begin
         report_error($sformatf("%0d responses never arrived", expected_pcm.size()));
      end
      if (error_count == 0) begin
         $display("sine_tone_pcm_generator: match");
      end else begin
         $display("sine_tone_pcm_generator: mismatch");
      end
      $finish;
   end

endmodule
